[hdl/bmms_pkg.sv]
// Shared constants, payload types and sequencer states for the band statistics block.
package bmms_pkg;

  localparam int COUNT_BITS  = 24;
  localparam int SAMPLE_BITS = 8;
  localparam int FRAC_BITS   = 8;
  localparam int RES_W       = 16;

  localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_W   = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int PROD_W = 2 * SUM_W;
  localparam int PAIR_W = 2 * COUNT_BITS;
  localparam int TGT_W  = PROD_W + 2 * FRAC_BITS;
  localparam int RAD_W  = 2 * RES_W;
  localparam int REM_W  = RES_W + 2;

  localparam int MUL_DIGIT = 8;
  localparam int MUL_STEPS = (SUM_W + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int MUL_B_W   = MUL_STEPS * MUL_DIGIT;
  localparam int MUL_CNT_W = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;
  localparam int DIV_CNT_W = $clog2(TGT_W);
  localparam int SQ_CNT_W  = $clog2(RES_W);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0] sample;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  min_value;
    logic [7:0]  max_value;
    logic [15:0] mean_q8;
    logic [15:0] std_q8;
    logic [23:0] sample_count;
    logic        single_sample;
    logic        overflow;
  } out_res_t;

  // Snapshot of one finished band, handed from front to back.
  typedef struct packed {
    logic [COUNT_BITS-1:0]  count;
    logic [SUM_W-1:0]       sum;
    logic [SQ_W-1:0]        sq;
    logic [SAMPLE_BITS-1:0] min;
    logic [SAMPLE_BITS-1:0] max;
    logic                   sat;
  } band_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_NSQ,
    ST_MUL_SS,
    ST_SUB,
    ST_MUL_PAIRS,
    ST_DIV_MEAN,
    ST_DIV_VAR,
    ST_SQRT,
    ST_EMIT
  } back_state_t;

endpackage

[hdl/band_min_max_mean_stddev.sv]
// Band statistics: min, max, Q8 mean and Q8 sample deviation per band of pixel samples.
//
// Input channel in_*: one unsigned 8-bit sample per request, last marks the end of a band.
// Samples are taken one per cycle; the front keeps count, sum, sum of squares, min and max.
// On last a snapshot of the band goes into a two-entry queue and the accumulators clear.
// Result channel out_*: one result per band, held in an output register until taken.
// Back end work per band: a pop, three digit-serial products
// (n*sumsq, sum*sum, n*(n-1)), one subtract, two bit-serial divisions
// (mean, then variance), a square root and the output load.
// A one-sample band skips the variance division and the root.
// Sample throughput is one per cycle; in_ready drops only while the queue holds two
// unprocessed bands, so short bands are limited by the back end's divider.
// A stalled receiver holds the result register and the back end waits; the front keeps
// taking samples until the queue fills.
// Reset (rst_n low, synchronous) empties the queue, clears the accumulators and drops
// out_valid.
module band_min_max_mean_stddev (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bmms_pkg::in_req_t   in_payload,
  output logic                out_valid,
  input  logic                out_ready,
  output bmms_pkg::out_res_t  out_payload
);

  logic                  push, pop;
  bmms_pkg::band_job_t   push_data, pop_data;
  bmms_pkg::fifo_stat_t  fifo_stat;

  bmms_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_payload (in_payload),
    .fifo_stat  (fifo_stat),
    .push       (push),
    .push_data  (push_data)
  );

  bmms_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .fifo_stat (fifo_stat)
  );

  bmms_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .fifo_stat   (fifo_stat),
    .pop_data    (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

endmodule

[hdl/bmms_front.sv]
// Front end: takes samples, keeps the running band accumulators, pushes a snapshot on last.
module bmms_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bmms_pkg::in_req_t     in_payload,
  input  bmms_pkg::fifo_stat_t  fifo_stat,
  output logic                  push,
  output bmms_pkg::band_job_t   push_data
);

  logic [bmms_pkg::COUNT_BITS-1:0]  total_r, total_nxt;
  logic [bmms_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic [bmms_pkg::SQ_W-1:0]        sq_r, sq_nxt;
  logic [bmms_pkg::SAMPLE_BITS-1:0] min_r, min_nxt;
  logic [bmms_pkg::SAMPLE_BITS-1:0] max_r, max_nxt;
  logic                             sat_r, sat_nxt;

  logic                                 accept;
  logic [bmms_pkg::SAMPLE_BITS-1:0]     x;
  logic [2*bmms_pkg::SAMPLE_BITS-1:0]   x_sq;
  bmms_pkg::band_job_t                  upd;

  assign in_ready = !fifo_stat.full;
  assign accept   = in_valid && in_ready;
  assign x        = in_payload.sample[bmms_pkg::SAMPLE_BITS-1:0];
  assign x_sq     = (2*bmms_pkg::SAMPLE_BITS)'(x) * (2*bmms_pkg::SAMPLE_BITS)'(x);

  always_comb begin
    upd.min = (x < min_r) ? x : min_r;
    upd.max = (x > max_r) ? x : max_r;
    if (total_r == '1) begin
      // count full: later samples only touch min, max and the flag
      upd.count = total_r;
      upd.sum   = sum_r;
      upd.sq    = sq_r;
      upd.sat   = 1'b1;
    end else begin
      upd.count = total_r + 1'b1;
      upd.sum   = sum_r + bmms_pkg::SUM_W'(x);
      upd.sq    = sq_r + bmms_pkg::SQ_W'(x_sq);
      upd.sat   = sat_r;
    end
  end

  assign push      = accept && in_payload.last;
  assign push_data = upd;

  always_comb begin
    total_nxt = total_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    sat_nxt   = sat_r;
    if (accept) begin
      if (in_payload.last) begin
        total_nxt = '0;
        sum_nxt   = '0;
        sq_nxt    = '0;
        min_nxt   = '1;
        max_nxt   = '0;
        sat_nxt   = 1'b0;
      end else begin
        total_nxt = upd.count;
        sum_nxt   = upd.sum;
        sq_nxt    = upd.sq;
        min_nxt   = upd.min;
        max_nxt   = upd.max;
        sat_nxt   = upd.sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      min_r   <= '1;
      max_r   <= '0;
      sat_r   <= 1'b0;
    end else begin
      total_r <= total_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      sat_r   <= sat_nxt;
    end
  end

endmodule

[hdl/bmms_fifo.sv]
// Short queue of finished band snapshots between front and back.
module bmms_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  bmms_pkg::band_job_t   push_data,
  input  logic                  pop,
  output bmms_pkg::band_job_t   pop_data,
  output bmms_pkg::fifo_stat_t  fifo_stat
);

  bmms_pkg::band_job_t             slot_r [bmms_pkg::FIFO_DEPTH];
  logic [bmms_pkg::FIFO_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [bmms_pkg::FIFO_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [bmms_pkg::FIFO_AW:0]      fill_r, fill_nxt;
  logic                            do_push, do_pop;

  assign fifo_stat.empty = (fill_r == '0);
  assign fifo_stat.full  = (fill_r == (bmms_pkg::FIFO_AW+1)'(bmms_pkg::FIFO_DEPTH));
  assign do_push = push && !fifo_stat.full;
  assign do_pop  = pop && !fifo_stat.empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hdl/bmms_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the mean and variance paths.
module bmms_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bmms_pkg::TGT_W-1:0]    dividend,
  input  logic [bmms_pkg::PAIR_W-1:0]   divisor,
  output logic                          done,
  output logic [bmms_pkg::TGT_W-1:0]    quotient
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [bmms_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [bmms_pkg::TGT_W-1:0]       dvd_r, dvd_nxt;
  logic [bmms_pkg::PAIR_W-1:0]      rem_r, rem_nxt;
  logic [bmms_pkg::PAIR_W-1:0]      dsr_r, dsr_nxt;

  logic [bmms_pkg::PAIR_W:0]        rem_sh, rem_dif;
  logic                             fits;

  assign rem_sh  = {rem_r, dvd_r[bmms_pkg::TGT_W-1]};
  assign fits    = rem_sh >= {1'b0, dsr_r};
  assign rem_dif = rem_sh - {1'b0, dsr_r};

  assign done     = done_r;
  assign quotient = dvd_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // quotient bits shift in behind the dividend bits
      dvd_nxt = {dvd_r[bmms_pkg::TGT_W-2:0], fits};
      rem_nxt = fits ? rem_dif[bmms_pkg::PAIR_W-1:0] : rem_sh[bmms_pkg::PAIR_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == bmms_pkg::DIV_CNT_W'(bmms_pkg::TGT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

[hdl/bmms_back.sv]
// Back end: per band products, mean and variance division, square root, result register.
module bmms_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bmms_pkg::fifo_stat_t  fifo_stat,
  input  bmms_pkg::band_job_t   pop_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bmms_pkg::out_res_t    out_payload
);

  bmms_pkg::back_state_t            state_r, state_nxt;
  bmms_pkg::band_job_t              job_r, job_nxt;
  logic [bmms_pkg::PROD_W-1:0]      prod_r, prod_nxt;
  logic [bmms_pkg::MUL_CNT_W-1:0]   mul_cnt_r, mul_cnt_nxt;
  logic [bmms_pkg::PROD_W-1:0]      nsq_r, nsq_nxt;
  logic [bmms_pkg::PROD_W-1:0]      diff_r, diff_nxt;
  logic [bmms_pkg::PAIR_W-1:0]      pairs_r, pairs_nxt;
  logic [bmms_pkg::RES_W-1:0]       mean_r, mean_nxt;
  logic [bmms_pkg::RAD_W-1:0]       rad_r, rad_nxt;
  logic [bmms_pkg::RES_W-1:0]       root_r, root_nxt;
  logic [bmms_pkg::REM_W-1:0]       rem_r, rem_nxt;
  logic [bmms_pkg::SQ_CNT_W-1:0]    sq_cnt_r, sq_cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  bmms_pkg::out_res_t               out_res_r, out_res_nxt;

  // shared multiplier, one 8-bit digit of b per cycle, msb digit first
  logic [bmms_pkg::SQ_W-1:0]                    mul_a;
  logic [bmms_pkg::MUL_B_W-1:0]                 mul_b;
  logic [bmms_pkg::MUL_CNT_W-1:0]               digit_sel;
  logic [bmms_pkg::MUL_DIGIT-1:0]               digit;
  logic [bmms_pkg::SQ_W+bmms_pkg::MUL_DIGIT-1:0] partial;
  logic [bmms_pkg::PROD_W-1:0]                  mul_sum;
  logic                                         mul_last;

  logic                             div_start, div_done;
  logic [bmms_pkg::TGT_W-1:0]       div_dividend, div_q;
  logic [bmms_pkg::PAIR_W-1:0]      div_divisor;

  logic [bmms_pkg::REM_W-1:0]       sq_rem_sh, sq_trial;

  always_comb begin
    case (state_r)
      bmms_pkg::ST_MUL_NSQ: begin
        mul_a = job_r.sq;
        mul_b = bmms_pkg::MUL_B_W'(job_r.count);
      end
      bmms_pkg::ST_MUL_SS: begin
        mul_a = bmms_pkg::SQ_W'(job_r.sum);
        mul_b = bmms_pkg::MUL_B_W'(job_r.sum);
      end
      default: begin
        mul_a = bmms_pkg::SQ_W'(job_r.count);
        mul_b = bmms_pkg::MUL_B_W'(job_r.count - 1'b1);
      end
    endcase
  end

  assign digit_sel = bmms_pkg::MUL_CNT_W'(bmms_pkg::MUL_STEPS - 1) - mul_cnt_r;
  assign digit     = mul_b[int'(digit_sel) * bmms_pkg::MUL_DIGIT +: bmms_pkg::MUL_DIGIT];
  assign partial   = (bmms_pkg::SQ_W + bmms_pkg::MUL_DIGIT)'(mul_a)
                   * (bmms_pkg::SQ_W + bmms_pkg::MUL_DIGIT)'(digit);
  assign mul_sum   = (prod_r << bmms_pkg::MUL_DIGIT) + bmms_pkg::PROD_W'(partial);
  assign mul_last  = (mul_cnt_r == bmms_pkg::MUL_CNT_W'(bmms_pkg::MUL_STEPS - 1));

  // the variance division is started from the mean wait state
  always_comb begin
    if (state_r == bmms_pkg::ST_DIV_MEAN) begin
      div_dividend = {diff_r, (2*bmms_pkg::FRAC_BITS)'(0)};
      div_divisor  = pairs_r;
    end else begin
      div_dividend = bmms_pkg::TGT_W'({job_r.sum, bmms_pkg::FRAC_BITS'(0)});
      div_divisor  = bmms_pkg::PAIR_W'(job_r.count);
    end
  end

  bmms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // digit-by-digit square root, two radicand bits per step
  assign sq_rem_sh = {rem_r[bmms_pkg::REM_W-3:0], rad_r[bmms_pkg::RAD_W-1 -: 2]};
  assign sq_trial  = {root_r, 2'b01};

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    prod_nxt      = prod_r;
    mul_cnt_nxt   = mul_cnt_r;
    nsq_nxt       = nsq_r;
    diff_nxt      = diff_r;
    pairs_nxt     = pairs_r;
    mean_nxt      = mean_r;
    rad_nxt       = rad_r;
    root_nxt      = root_r;
    rem_nxt       = rem_r;
    sq_cnt_nxt    = sq_cnt_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    pop           = 1'b0;
    div_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bmms_pkg::ST_IDLE: begin
        if (!fifo_stat.empty) begin
          pop         = 1'b1;
          job_nxt     = pop_data;
          prod_nxt    = '0;
          mul_cnt_nxt = '0;
          state_nxt   = bmms_pkg::ST_MUL_NSQ;
        end
      end
      bmms_pkg::ST_MUL_NSQ: begin
        prod_nxt    = mul_sum;
        mul_cnt_nxt = mul_cnt_r + 1'b1;
        if (mul_last) begin
          nsq_nxt     = mul_sum;
          prod_nxt    = '0;
          mul_cnt_nxt = '0;
          state_nxt   = bmms_pkg::ST_MUL_SS;
        end
      end
      bmms_pkg::ST_MUL_SS: begin
        prod_nxt    = mul_sum;
        mul_cnt_nxt = mul_cnt_r + 1'b1;
        if (mul_last) begin
          mul_cnt_nxt = '0;
          state_nxt   = bmms_pkg::ST_SUB;
        end
      end
      bmms_pkg::ST_SUB: begin
        diff_nxt  = (nsq_r > prod_r) ? nsq_r - prod_r : '0;
        prod_nxt  = '0;
        state_nxt = bmms_pkg::ST_MUL_PAIRS;
      end
      bmms_pkg::ST_MUL_PAIRS: begin
        prod_nxt    = mul_sum;
        mul_cnt_nxt = mul_cnt_r + 1'b1;
        if (mul_last) begin
          pairs_nxt   = mul_sum[bmms_pkg::PAIR_W-1:0];
          mul_cnt_nxt = '0;
          div_start   = 1'b1;
          state_nxt   = bmms_pkg::ST_DIV_MEAN;
        end
      end
      bmms_pkg::ST_DIV_MEAN: begin
        if (div_done) begin
          if (job_r.count == '0) begin
            mean_nxt = '0;
          end else if (|div_q[bmms_pkg::TGT_W-1:bmms_pkg::RES_W]) begin
            mean_nxt = '1;
          end else begin
            mean_nxt = div_q[bmms_pkg::RES_W-1:0];
          end
          if (job_r.count > bmms_pkg::COUNT_BITS'(1)) begin
            div_start = 1'b1;
            state_nxt = bmms_pkg::ST_DIV_VAR;
          end else begin
            root_nxt  = '0;
            state_nxt = bmms_pkg::ST_EMIT;
          end
        end
      end
      bmms_pkg::ST_DIV_VAR: begin
        if (div_done) begin
          // any quotient at or above 2^32 gives the all-ones root
          rad_nxt    = (|div_q[bmms_pkg::TGT_W-1:bmms_pkg::RAD_W]) ? '1
                                                                    : div_q[bmms_pkg::RAD_W-1:0];
          root_nxt   = '0;
          rem_nxt    = '0;
          sq_cnt_nxt = '0;
          state_nxt  = bmms_pkg::ST_SQRT;
        end
      end
      bmms_pkg::ST_SQRT: begin
        rad_nxt    = rad_r << 2;
        sq_cnt_nxt = sq_cnt_r + 1'b1;
        if (sq_rem_sh >= sq_trial) begin
          rem_nxt  = sq_rem_sh - sq_trial;
          root_nxt = {root_r[bmms_pkg::RES_W-2:0], 1'b1};
        end else begin
          rem_nxt  = sq_rem_sh;
          root_nxt = {root_r[bmms_pkg::RES_W-2:0], 1'b0};
        end
        if (sq_cnt_r == bmms_pkg::SQ_CNT_W'(bmms_pkg::RES_W - 1)) begin
          state_nxt = bmms_pkg::ST_EMIT;
        end
      end
      bmms_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_res_nxt.min_value     = 8'(job_r.min);
          out_res_nxt.max_value     = 8'(job_r.max);
          out_res_nxt.mean_q8       = mean_r;
          out_res_nxt.std_q8        = root_r;
          out_res_nxt.sample_count  = 24'(job_r.count);
          out_res_nxt.single_sample = (job_r.count == bmms_pkg::COUNT_BITS'(1));
          out_res_nxt.overflow      = job_r.sat;
          state_nxt                 = bmms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bmms_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmms_pkg::ST_IDLE;
      mul_cnt_r   <= '0;
      sq_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mul_cnt_r   <= mul_cnt_nxt;
      sq_cnt_r    <= sq_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    prod_r    <= prod_nxt;
    nsq_r     <= nsq_nxt;
    diff_r    <= diff_nxt;
    pairs_r   <= pairs_nxt;
    mean_r    <= mean_nxt;
    rad_r     <= rad_nxt;
    root_r    <= root_nxt;
    rem_r     <= rem_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_res_r;

endmodule

[hdl/bmms_checker.sv]
// Port-level checks for the band statistics block, bound to the top level.
module bmms_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input bmms_pkg::in_req_t   in_payload,
  input logic                out_valid,
  input logic                out_ready,
  input bmms_pkg::out_res_t  out_payload
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  // the mean of the counted samples lies between min and max
  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload.mean_q8 >= {out_payload.min_value, 8'h00})
               && (out_payload.mean_q8 <= {out_payload.max_value, 8'h00}))
    else $error("mean outside band range");

  a_single_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_payload.single_sample == (out_payload.sample_count == 24'd1))
    else $error("single_sample does not match count");

  a_single_std: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.single_sample |-> out_payload.std_q8 == 16'd0)
    else $error("deviation nonzero for one-sample band");

  // a waiting sample request stays put until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_payload))
    else $error("sample request changed while waiting");

endmodule

bind band_min_max_mean_stddev bmms_checker u_bmms_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_payload  (in_payload),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_payload (out_payload)
);
